// File: rtl/core/odjm_pkg.sv
// ----------------------------------------------------------------------------
// odjm_pkg
// Shared widths, register indexes, result codes and reset values of the
// omni-drive joystick mixer.
// ----------------------------------------------------------------------------
package odjm_pkg;

  localparam int unsigned ButtonCountDef = 17;
  localparam int unsigned ButtonW        = 17;
  localparam int unsigned AxisW          = 16;
  localparam int unsigned GainW          = 16;
  localparam int unsigned TrigW          = 15;
  localparam int unsigned TickW          = 8;
  localparam int unsigned CodeW          = 13;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 16;

  localparam int unsigned BtnFast = 10;
  localparam int unsigned BtnKick = 11;
  localparam int unsigned BtnDrib = 13;

  localparam logic [CfgIdxW-1:0] CfgGainXyNormal  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGainRotNormal = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainXyFast    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGainRotFast   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgWheelSin      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgWheelCos      = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgTimeoutTicks  = 3'd6;

  localparam logic [GainW-1:0] GainXyNormalRst  = 16'd26214;
  localparam logic [GainW-1:0] GainRotNormalRst = 16'd13107;
  localparam logic [GainW-1:0] GainXyFastRst    = 16'd45875;
  localparam logic [GainW-1:0] GainRotFastRst   = 16'd19661;
  localparam logic [TrigW-1:0] WheelSinRst      = 15'd21063;
  localparam logic [TrigW-1:0] WheelCosRst      = 15'd25101;
  localparam logic [TickW-1:0] TimeoutRst       = 8'd20;

  localparam logic [1:0] ModeIdle = 2'd0;
  localparam logic [1:0] ModeMove = 2'd1;
  localparam logic [1:0] ModeStop = 2'd2;

  localparam logic [1:0] DribNone = 2'd0;
  localparam logic [1:0] DribOff  = 2'd1;
  localparam logic [1:0] DribOn   = 2'd2;

  localparam logic [1:0] KickNone   = 2'd0;
  localparam logic [1:0] KickCharge = 2'd1;
  localparam logic [1:0] KickShoot  = 2'd2;

  localparam logic [CodeW-1:0] CodeMid = 13'd4096;
  localparam logic [CodeW-1:0] CodeLo  = 13'd2048;
  localparam logic [CodeW-1:0] CodeHi  = 13'd6144;

endpackage

// File: rtl/core/omni_drive_joystick_mixer_unit.sv
// ----------------------------------------------------------------------------
// omni_drive_joystick_mixer_unit
// Mixes one joystick tick into four omni-wheel drive codes with one shared
// multiplier, and tracks dribbler, kick and idle-timeout status.
// ----------------------------------------------------------------------------
// Sequence: a message tick goes from accept through five multiplier steps,
//   four mix steps and one load to out_valid_o; a tick without message goes
//   straight to the load. No new tick is taken until the last one is loaded,
//   which takes the five passes through the shared 32x17 multiplier and the
//   four passes through the shared mix adder; a waiting result holds the next.
// Reset: clears control, button history, dribbler and idle count; gains,
//   wheel angle and timeout take their default values.
module omni_drive_joystick_mixer_unit
  import odjm_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = ButtonCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                has_new_i,
  input  logic signed [AxisW-1:0] axis_x_i,
  input  logic signed [AxisW-1:0] axis_y_i,
  input  logic signed [AxisW-1:0] axis_rot_i,
  input  logic [ButtonW-1:0]  buttons_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          mode_status_o,
  output logic [CodeW-1:0]    motor_0_o,
  output logic [CodeW-1:0]    motor_1_o,
  output logic [CodeW-1:0]    motor_2_o,
  output logic [CodeW-1:0]    motor_3_o,
  output logic [1:0]          dribble_event_o,
  output logic [1:0]          kick_event_o
);

  localparam int unsigned AxW    = AxisW + 1;
  localparam int unsigned MulAW  = 2 * GainW;
  localparam int unsigned ProdW  = MulAW + AxW;
  localparam int unsigned GtW    = GainW + TrigW;
  localparam int unsigned SumW   = ProdW + 1;
  localparam int unsigned FracSh = 15;
  localparam int unsigned OneSh  = 46;
  localparam int unsigned CodeSh = 35;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_MIX,
    ST_OUT
  } state_e;

  state_e state_q;
  logic [2:0] step_q;

  logic [GainW-1:0] gxy_n_q, grot_n_q, gxy_f_q, grot_f_q;
  logic [TrigW-1:0] sin_q, cos_q;
  logic [TickW-1:0] timeout_q;

  logic [ButtonW-1:0] last_btn_q;
  logic               drib_on_q;
  logic [TickW-1:0]   idle_q;

  logic                  fast_q;
  logic signed [AxW-1:0] x_q, y_q, r_q;
  logic [GtW-1:0]        gs_q, gc_q;
  logic signed [ProdW-1:0] a_q, b_q, rp_q;

  logic [1:0]       stg_mode_q, stg_drib_q, stg_kick_q;
  logic [CodeW-1:0] stg_motor_q [4];

  logic             out_valid_q;
  logic [1:0]       mode_q, drib_ev_q, kick_ev_q;
  logic [CodeW-1:0] motor_q [4];

  logic in_fire;
  logic out_free;
  logic [ButtonW-1:0] btn_mask, btn_now, press, unpress;
  logic [TickW-1:0]   idle_d;
  logic drib_on_d;
  logic [1:0] drib_ev_d, kick_ev_d;
  logic [GainW-1:0] g_sel, h_sel;

  logic signed [MulAW-1:0] mul_a;
  logic signed [AxW-1:0]   mul_b;
  logic signed [ProdW-1:0] mul_p;

  logic signed [SumW-1:0] a_ext, b_ext, r_ext, mix_sum;
  logic [CodeW-1:0]       mix_code;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    for (int i = 0; i < ButtonW; i++) begin
      btn_mask[i] = (i < BUTTON_COUNT);
    end
  end

  assign btn_now = buttons_i & btn_mask;
  assign press   = btn_now & ~last_btn_q;
  assign unpress = ~btn_now & last_btn_q;

  always_comb begin
    idle_d = (idle_q == {TickW{1'b1}}) ? idle_q : idle_q + 1'b1;
  end

  always_comb begin
    drib_on_d = drib_on_q;
    drib_ev_d = DribNone;
    if (press[BtnDrib]) begin
      drib_on_d = !drib_on_q;
      drib_ev_d = drib_on_q ? DribOff : DribOn;
    end
    if (press[BtnKick]) begin
      kick_ev_d = KickCharge;
    end else if (unpress[BtnKick]) begin
      kick_ev_d = KickShoot;
    end else begin
      kick_ev_d = KickNone;
    end
  end

  assign g_sel = fast_q ? gxy_f_q : gxy_n_q;
  assign h_sel = fast_q ? grot_f_q : grot_n_q;

  always_comb begin
    case (step_q)
      3'd0: begin
        mul_a = signed'({{(MulAW-GainW){1'b0}}, g_sel});
        mul_b = signed'({{(AxW-TrigW){1'b0}}, sin_q});
      end
      3'd1: begin
        mul_a = signed'({{(MulAW-GainW){1'b0}}, g_sel});
        mul_b = signed'({{(AxW-TrigW){1'b0}}, cos_q});
      end
      3'd2: begin
        mul_a = signed'({{(MulAW-GtW){1'b0}}, gs_q});
        mul_b = x_q;
      end
      3'd3: begin
        mul_a = signed'({{(MulAW-GtW){1'b0}}, gc_q});
        mul_b = y_q;
      end
      default: begin
        mul_a = signed'({{(MulAW-GainW){1'b0}}, h_sel});
        mul_b = r_q;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign a_ext = SumW'(a_q);
  assign b_ext = SumW'(b_q);
  assign r_ext = SumW'(rp_q) <<< FracSh;

  always_comb begin
    mix_sum = (step_q[1] ? a_ext : -a_ext) + (step_q[0] ? -b_ext : b_ext) - r_ext;
    if (mix_sum >= (SumW'(1) <<< OneSh)) begin
      mix_code = CodeHi;
    end else if (mix_sum <= -(SumW'(1) <<< OneSh)) begin
      mix_code = CodeLo;
    end else begin
      mix_code = mix_sum[CodeSh +: CodeW] + CodeMid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      gxy_n_q     <= GainXyNormalRst;
      grot_n_q    <= GainRotNormalRst;
      gxy_f_q     <= GainXyFastRst;
      grot_f_q    <= GainRotFastRst;
      sin_q       <= WheelSinRst;
      cos_q       <= WheelCosRst;
      timeout_q   <= TimeoutRst;
      last_btn_q  <= '0;
      drib_on_q   <= 1'b0;
      idle_q      <= '0;
      fast_q      <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      r_q         <= '0;
      gs_q        <= '0;
      gc_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      rp_q        <= '0;
      stg_mode_q  <= ModeIdle;
      stg_drib_q  <= DribNone;
      stg_kick_q  <= KickNone;
      mode_q      <= ModeIdle;
      drib_ev_q   <= DribNone;
      kick_ev_q   <= KickNone;
      for (int k = 0; k < 4; k++) begin
        stg_motor_q[k] <= CodeMid;
        motor_q[k]     <= CodeMid;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgGainXyNormal:  gxy_n_q   <= cfg_data_i[GainW-1:0];
          CfgGainRotNormal: grot_n_q  <= cfg_data_i[GainW-1:0];
          CfgGainXyFast:    gxy_f_q   <= cfg_data_i[GainW-1:0];
          CfgGainRotFast:   grot_f_q  <= cfg_data_i[GainW-1:0];
          CfgWheelSin:      sin_q     <= cfg_data_i[TrigW-1:0];
          CfgWheelCos:      cos_q     <= cfg_data_i[TrigW-1:0];
          CfgTimeoutTicks:  timeout_q <= cfg_data_i[TickW-1:0];
          default: ;
        endcase
      end

      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (has_new_i) begin
              idle_q     <= '0;
              last_btn_q <= btn_now;
              drib_on_q  <= drib_on_d;
              fast_q     <= btn_now[BtnFast];
              x_q        <= -AxW'(axis_x_i);
              y_q        <= AxW'(axis_y_i);
              r_q        <= -AxW'(axis_rot_i);
              stg_mode_q <= ModeMove;
              stg_drib_q <= drib_ev_d;
              stg_kick_q <= kick_ev_d;
              step_q     <= '0;
              state_q    <= ST_MUL;
            end else begin
              idle_q     <= idle_d;
              stg_mode_q <= (idle_d > timeout_q) ? ModeStop : ModeIdle;
              stg_drib_q <= DribNone;
              stg_kick_q <= KickNone;
              for (int k = 0; k < 4; k++) begin
                stg_motor_q[k] <= CodeMid;
              end
              state_q    <= ST_OUT;
            end
          end
        end
        ST_MUL: begin
          case (step_q)
            3'd0:    gs_q <= mul_p[GtW-1:0];
            3'd1:    gc_q <= mul_p[GtW-1:0];
            3'd2:    a_q  <= mul_p;
            3'd3:    b_q  <= mul_p;
            default: rp_q <= mul_p;
          endcase
          if (step_q == 3'd4) begin
            step_q  <= '0;
            state_q <= ST_MIX;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_MIX: begin
          stg_motor_q[step_q[1:0]] <= mix_code;
          if (step_q == 3'd3) begin
            step_q  <= '0;
            state_q <= ST_OUT;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            mode_q      <= stg_mode_q;
            drib_ev_q   <= stg_drib_q;
            kick_ev_q   <= stg_kick_q;
            for (int k = 0; k < 4; k++) begin
              motor_q[k] <= stg_motor_q[k];
            end
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mode_status_o   = mode_q;
  assign motor_0_o       = motor_q[0];
  assign motor_1_o       = motor_q[1];
  assign motor_2_o       = motor_q[2];
  assign motor_3_o       = motor_q[3];
  assign dribble_event_o = drib_ev_q;
  assign kick_event_o    = kick_ev_q;

endmodule
